/* rtl/ldf_pkg.sv */
// shared types and constants for the length prefixed deframer
package ldf_pkg;

    localparam int MAX_PREFIX       = 8;
    localparam int MAX_LENGTH_BYTES = 4;
    localparam int STORE_DEPTH      = MAX_PREFIX + MAX_LENGTH_BYTES;
    localparam int CNT_W            = 4;
    localparam int QUEUE_DEPTH      = 4;
    localparam int QPTR_W           = 2;

    localparam logic [1:0] REG_LENGTH_BYTES = 2'd0;
    localparam logic [1:0] REG_MSB_FIRST    = 2'd1;
    localparam logic [1:0] REG_PREFIX_BYTES = 2'd2;
    localparam logic [1:0] REG_MAX_PAYLOAD  = 2'd3;

    typedef enum logic [1:0] {
        PH_HEADER  = 2'd0,
        PH_PAYLOAD = 2'd1,
        PH_DISCARD = 2'd2
    } phase_t;

    typedef enum logic [1:0] {
        CMD_BYTE   = 2'd0,
        CMD_ERROR  = 2'd1,
        CMD_REPLAY = 2'd2
    } cmd_kind_t;

    typedef struct packed {
        logic [7:0] in_byte;
        logic       chunk_last;
    } in_item_t;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       frame_first;
        logic       frame_last;
        logic       length_error;
    } out_item_t;

    typedef struct packed {
        logic [2:0]  length_bytes;
        logic        msb_first;
        logic [3:0]  prefix_bytes;
        logic [31:0] max_payload;
    } cfg_t;

    typedef struct packed {
        cmd_kind_t        kind;
        logic [7:0]       data;
        logic             last;
        logic [CNT_W-1:0] count;
    } cmd_t;

    typedef struct packed {
        logic                              load;
        logic [STORE_DEPTH-1:0][7:0]       bytes;
    } snap_load_t;

endpackage

/* rtl/ldf_fifo.sv */
// short command queue between the front and back parts
module ldf_fifo (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    input  ldf_pkg::cmd_t push_cmd,
    input  logic          pop,
    output ldf_pkg::cmd_t head,
    output logic          empty,
    output logic          full
);

    ldf_pkg::cmd_t                 mem_reg [ldf_pkg::QUEUE_DEPTH];
    logic [ldf_pkg::QPTR_W-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [ldf_pkg::QPTR_W-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [ldf_pkg::QPTR_W:0]      count_reg, count_next;

    assign empty = (count_reg == '0);
    assign full  = (count_reg == (ldf_pkg::QPTR_W + 1)'(ldf_pkg::QUEUE_DEPTH));
    assign head  = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule

/* rtl/ldf_front.sv */
// front part: header collection, length decode and item classification
module ldf_front (
    input  logic                 clk,
    input  logic                 rst_n,
    input  ldf_pkg::cfg_t        cfg,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  ldf_pkg::in_item_t    in_item,
    input  logic                 queue_full,
    input  logic                 replay_busy,
    output logic                 push,
    output ldf_pkg::cmd_t        push_cmd,
    output ldf_pkg::snap_load_t  snap
);

    localparam int DEPTH = ldf_pkg::STORE_DEPTH;
    localparam int CW    = ldf_pkg::CNT_W;

    ldf_pkg::phase_t   phase_reg, phase_next;
    logic [CW-1:0]     count_reg, count_next;
    logic [31:0]       left_reg, left_next;
    logic [7:0]        store_reg [DEPTH];

    logic [2:0]        eff_lb;
    logic [CW-1:0]     eff_pre;
    logic [CW-1:0]     total;
    logic [CW-1:0]     cnt_inc;
    logic              complete;
    logic              accept;
    logic [DEPTH-1:0][7:0] hdr;
    logic [31:0]       len;
    logic [31:0]       left_dec;
    logic              too_long;

    always_comb
    begin
        if (cfg.length_bytes == 3'd0)
        begin
            eff_lb = 3'd1;
        end
        else if (cfg.length_bytes > 3'(ldf_pkg::MAX_LENGTH_BYTES))
        begin
            eff_lb = 3'(ldf_pkg::MAX_LENGTH_BYTES);
        end
        else
        begin
            eff_lb = cfg.length_bytes;
        end
        if (cfg.prefix_bytes > CW'(ldf_pkg::MAX_PREFIX))
        begin
            eff_pre = CW'(ldf_pkg::MAX_PREFIX);
        end
        else
        begin
            eff_pre = cfg.prefix_bytes;
        end
    end

    assign total    = eff_pre + CW'(eff_lb);
    assign cnt_inc  = count_reg + 1'b1;
    assign complete = (cnt_inc >= total);
    assign in_ready = !queue_full &&
                      !((phase_reg == ldf_pkg::PH_HEADER) && complete && replay_busy);
    assign accept   = in_valid && in_ready;
    assign left_dec = left_reg - 32'd1;

    // header bytes with the current item in place
    always_comb
    begin
        for (int j = 0; j < DEPTH; j++)
        begin
            hdr[j] = (CW'(j) == count_reg) ? in_item.in_byte : store_reg[j];
        end
    end

    always_comb
    begin
        logic [CW-1:0] idx;
        logic [7:0]    v;
        len = '0;
        for (int i = 0; i < ldf_pkg::MAX_LENGTH_BYTES; i++)
        begin
            idx = eff_pre + CW'(i);
            v   = (idx < CW'(DEPTH)) ? hdr[idx] : 8'd0;
            if (3'(i) < eff_lb)
            begin
                if (cfg.msb_first)
                begin
                    len = {len[23:0], v};
                end
                else
                begin
                    len = len | ({24'd0, v} << (8 * i));
                end
            end
        end
    end

    assign too_long   = (len > cfg.max_payload);

    always_comb
    begin
        phase_next = phase_reg;
        count_next = count_reg;
        left_next  = left_reg;
        push       = 1'b0;
        push_cmd   = '{kind: ldf_pkg::CMD_BYTE, data: in_item.in_byte,
                       last: 1'b0, count: cnt_inc};
        snap.load  = 1'b0;
        snap.bytes = hdr;
        if (accept)
        begin
            unique case (phase_reg)
                ldf_pkg::PH_DISCARD:
                begin
                    if (in_item.chunk_last)
                    begin
                        phase_next = ldf_pkg::PH_HEADER;
                    end
                end
                ldf_pkg::PH_PAYLOAD:
                begin
                    left_next     = left_dec;
                    push          = 1'b1;
                    push_cmd.last = (left_dec == '0);
                    if (left_dec == '0)
                    begin
                        phase_next = ldf_pkg::PH_HEADER;
                    end
                end
                ldf_pkg::PH_HEADER:
                begin
                    if (count_reg < CW'(DEPTH))
                    begin
                        count_next = cnt_inc;
                    end
                    if (complete)
                    begin
                        count_next = '0;
                        push       = 1'b1;
                        if (too_long)
                        begin
                            push_cmd.kind = ldf_pkg::CMD_ERROR;
                            phase_next    = in_item.chunk_last ? ldf_pkg::PH_HEADER
                                                               : ldf_pkg::PH_DISCARD;
                        end
                        else
                        begin
                            push_cmd.kind = ldf_pkg::CMD_REPLAY;
                            push_cmd.last = (len == '0);
                            snap.load     = 1'b1;
                            left_next     = len;
                            phase_next    = (len == '0) ? ldf_pkg::PH_HEADER
                                                        : ldf_pkg::PH_PAYLOAD;
                        end
                    end
                end
                default:
                begin
                    phase_next = ldf_pkg::PH_HEADER;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= ldf_pkg::PH_HEADER;
            count_reg <= '0;
            left_reg  <= '0;
        end
        else
        begin
            phase_reg <= phase_next;
            count_reg <= count_next;
            left_reg  <= left_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept && (phase_reg == ldf_pkg::PH_HEADER) && (count_reg < CW'(DEPTH)))
        begin
            store_reg[count_reg[CW-1:0]] <= in_item.in_byte;
        end
    end

endmodule

/* rtl/ldf_back.sv */
// back part: header replay, payload pass-through and output register
module ldf_back (
    input  logic                 clk,
    input  logic                 rst_n,
    input  ldf_pkg::snap_load_t  snap,
    output logic                 replay_busy,
    input  ldf_pkg::cmd_t        head,
    input  logic                 empty,
    output logic                 pop,
    output logic                 out_valid,
    input  logic                 out_ready,
    output ldf_pkg::out_item_t   out_item
);

    localparam int DEPTH = ldf_pkg::STORE_DEPTH;
    localparam int CW    = ldf_pkg::CNT_W;

    logic [7:0]          snap_reg [DEPTH];
    logic                busy_reg, busy_next;
    logic [CW-1:0]       idx_reg, idx_next;
    logic                out_valid_reg, out_valid_next;
    ldf_pkg::out_item_t  out_item_reg, out_item_next;
    logic                advance;
    logic                idx_end;

    assign replay_busy = busy_reg;
    assign out_valid   = out_valid_reg;
    assign out_item    = out_item_reg;
    assign advance     = !out_valid_reg || out_ready;
    assign idx_end     = (idx_reg == head.count - 1'b1);

    always_comb
    begin
        busy_next      = busy_reg || snap.load;
        idx_next       = idx_reg;
        out_valid_next = out_valid_reg;
        out_item_next  = out_item_reg;
        pop            = 1'b0;
        if (advance)
        begin
            out_valid_next = !empty;
            if (!empty)
            begin
                unique case (head.kind)
                    ldf_pkg::CMD_BYTE:
                    begin
                        out_item_next = '{out_byte: head.data, frame_first: 1'b0,
                                          frame_last: head.last, length_error: 1'b0};
                        pop = 1'b1;
                    end
                    ldf_pkg::CMD_ERROR:
                    begin
                        out_item_next = '{out_byte: 8'd0, frame_first: 1'b0,
                                          frame_last: 1'b0, length_error: 1'b1};
                        pop = 1'b1;
                    end
                    ldf_pkg::CMD_REPLAY:
                    begin
                        out_item_next = '{out_byte: snap_reg[idx_reg],
                                          frame_first: (idx_reg == '0),
                                          frame_last: idx_end && head.last,
                                          length_error: 1'b0};
                        if (idx_end)
                        begin
                            pop       = 1'b1;
                            idx_next  = '0;
                            busy_next = 1'b0;
                        end
                        else
                        begin
                            idx_next = idx_reg + 1'b1;
                        end
                    end
                    default:
                    begin
                        pop = 1'b1;
                    end
                endcase
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg      <= 1'b0;
            idx_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            busy_reg      <= busy_next;
            idx_reg       <= idx_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_item_reg <= out_item_next;
        if (snap.load)
        begin
            for (int j = 0; j < DEPTH; j++)
            begin
                snap_reg[j] <= snap.bytes[j];
            end
        end
    end

endmodule

/* rtl/length_prefixed_deframer.sv */
// top level of the length prefixed deframer
//
// usage: one stream byte enters per item on the in channel (valid/ready),
// chunk_last marks the byte that ends a software write chunk. frame bytes
// leave on the out channel (valid/ready), header bytes first, then payload,
// with frame_first and frame_last marks; an over-limit length gives a single
// item with length_error set and input is dropped to the end of the chunk.
// configuration: cfg_write with cfg_index and cfg_data, taken the same cycle;
// the user must write only while the block is idle; the block does not enforce this.
// throughput: one item per cycle on both sides while nothing stalls; a
// completed header is replayed at one byte per cycle from a snapshot while
// the receiver is ready, and a second header cannot complete until the
// previous replay has drained, which stalls in.
// a four-entry command queue between front and back absorbs short stalls;
// when the receiver holds ready low the queue fills and in_ready drops.
// reset: registers return to two length bytes, big endian, no prefix and a
// payload limit of 4096; the deframer starts collecting a new header.
module length_prefixed_deframer (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_write,
    input  logic [1:0]          cfg_index,
    input  logic [31:0]         cfg_data,
    input  logic                in_valid,
    output logic                in_ready,
    input  ldf_pkg::in_item_t   in_item,
    output logic                out_valid,
    input  logic                out_ready,
    output ldf_pkg::out_item_t  out_item
);

    ldf_pkg::cfg_t        cfg_reg;
    logic                 queue_full;
    logic                 queue_empty;
    logic                 push;
    logic                 pop;
    ldf_pkg::cmd_t        push_cmd;
    ldf_pkg::cmd_t        head;
    logic                 replay_busy;
    ldf_pkg::snap_load_t  snap;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.length_bytes <= 3'd2;
            cfg_reg.msb_first    <= 1'b1;
            cfg_reg.prefix_bytes <= 4'd0;
            cfg_reg.max_payload  <= 32'd4096;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                ldf_pkg::REG_LENGTH_BYTES: cfg_reg.length_bytes <= cfg_data[2:0];
                ldf_pkg::REG_MSB_FIRST:    cfg_reg.msb_first    <= cfg_data[0];
                ldf_pkg::REG_PREFIX_BYTES: cfg_reg.prefix_bytes <= cfg_data[3:0];
                ldf_pkg::REG_MAX_PAYLOAD:  cfg_reg.max_payload  <= cfg_data;
                default:                   cfg_reg              <= cfg_reg;
            endcase
        end
    end

    ldf_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg         (cfg_reg),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .in_item     (in_item),
        .queue_full  (queue_full),
        .replay_busy (replay_busy),
        .push        (push),
        .push_cmd    (push_cmd),
        .snap        (snap)
    );

    ldf_fifo u_fifo (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_cmd (push_cmd),
        .pop      (pop),
        .head     (head),
        .empty    (queue_empty),
        .full     (queue_full)
    );

    ldf_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .snap        (snap),
        .replay_busy (replay_busy),
        .head        (head),
        .empty       (queue_empty),
        .pop         (pop),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .out_item    (out_item)
    );

endmodule
